### sv/packed_signal_deframer_core_macros.svh
// Assertion macros shared by the checker of the packed signal deframer.
`ifndef PACKED_SIGNAL_DEFRAMER_CORE_MACROS_SVH
`define PACKED_SIGNAL_DEFRAMER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define PSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed in the following cycle");

`endif

### sv/psd_pkg.sv
// Types and constants of the packed signal deframer.
package psd_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned BLOCK_W = 16;
  localparam int unsigned SIGLEN_W = 8;

  localparam logic [LEN_W:0]     LEN_BIAS      = 6'd3;
  localparam logic [LEN_W:0]     LEN_LIMIT     = 6'd25;
  localparam int unsigned        BLOCK_SHIFT   = 16;
  localparam logic [BLOCK_W-1:0] MIN_API_RESET = 16'd32768;

  typedef struct packed {
    logic [BLOCK_W-1:0] dest_block;
    logic [LEN_W-1:0]   sub_length;
    logic [WORD_W-1:0]  payload_word;
    logic [LEN_W-1:0]   word_index;
    logic               last_of_packet;
  } psd_result_t;

endpackage

### sv/psd_if.sv
// Valid/ready channel interfaces for the deframer's input words and results.
interface psd_in_if import psd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   data_word;
  logic                start_of_signal;
  logic [SIGLEN_W-1:0] signal_length;

  modport source (output valid, data_word, start_of_signal, signal_length, input ready);
  modport sink   (input valid, data_word, start_of_signal, signal_length, output ready);
endinterface

interface psd_out_if import psd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BLOCK_W-1:0] dest_block;
  logic [LEN_W-1:0]   sub_length;
  logic [WORD_W-1:0]  payload_word;
  logic [LEN_W-1:0]   word_index;
  logic               last_of_packet;

  modport source (output valid, dest_block, sub_length, payload_word, word_index,
                  last_of_packet, input ready);
  modport sink   (input valid, dest_block, sub_length, payload_word, word_index,
                  last_of_packet, output ready);
endinterface

### sv/packed_signal_deframer_core.sv
// Top level of the packed signal deframer.
//
//   channel    direction  handshake        carries
//   in_item    sink       valid/ready      data_word, start_of_signal, signal_length
//   out_item   source     valid/ready      dest_block, sub_length, payload_word,
//                                          word_index, last_of_packet
//   cfg        write      cfg_wr_en        min_api_block
//
// One word is taken per cycle; its result, if any, appears at the output the next cycle.
// The rate is set by the single result register: a word is taken whenever it is empty
// or being read in the same cycle.
// A stalled output holds its result and holds off input only while it stays full.
// Synchronous active-low reset clears the framing state and sets min_api_block to 32768.
module packed_signal_deframer_core import psd_pkg::*; #(
  parameter int unsigned MAX_SIGNAL_WORDS = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  psd_in_if.sink             in_item,
  psd_out_if.source          out_item,
  input  logic               cfg_wr_en,
  input  logic [BLOCK_W-1:0] cfg_wr_data
);

  logic [BLOCK_W-1:0] min_api_r;
  logic               accept, res_valid, can_load, out_valid;
  psd_result_t        res, out_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_api_r <= MIN_API_RESET;
    end else if (cfg_wr_en) begin
      min_api_r <= cfg_wr_data;
    end
  end

  assign in_item.ready = can_load;
  assign accept        = in_item.valid && can_load;

  psd_ctrl #(
    .MAX_SIGNAL_WORDS(MAX_SIGNAL_WORDS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .data_word      (in_item.data_word),
    .start_of_signal(in_item.start_of_signal),
    .signal_length  (in_item.signal_length),
    .min_api_block  (min_api_r),
    .res_valid      (res_valid),
    .res            (res)
  );

  psd_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_valid(res_valid),
    .res      (res),
    .out_ready(out_item.ready),
    .out_valid(out_valid),
    .out_data (out_data),
    .can_load (can_load)
  );

  assign out_item.valid          = out_valid;
  assign out_item.dest_block     = out_data.dest_block;
  assign out_item.sub_length     = out_data.sub_length;
  assign out_item.payload_word   = out_data.payload_word;
  assign out_item.word_index     = out_data.word_index;
  assign out_item.last_of_packet = out_data.last_of_packet;

endmodule

### sv/psd_ctrl.sv
// Framing state and header decode: updates the counters on each accepted word.
module psd_ctrl import psd_pkg::*; #(
  parameter int unsigned MAX_SIGNAL_WORDS = 255
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [WORD_W-1:0]   data_word,
  input  logic                start_of_signal,
  input  logic [SIGLEN_W-1:0] signal_length,
  input  logic [BLOCK_W-1:0]  min_api_block,
  output logic                res_valid,
  output psd_result_t         res
);

  localparam int unsigned CAP   = (MAX_SIGNAL_WORDS < 255) ? MAX_SIGNAL_WORDS : 255;
  localparam int unsigned CNT_W = $clog2(CAP + 1);
  localparam int unsigned SUM_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
  localparam logic [SIGLEN_W-1:0] CAP_LEN = SIGLEN_W'(CAP);

  logic [CNT_W-1:0]   consumed_r, consumed_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic [LEN_W-1:0]   left_r, left_nxt;
  logic [BLOCK_W-1:0] block_r, block_nxt;
  logic [LEN_W-1:0]   length_r, length_nxt;
  logic               deliver_r, deliver_nxt;

  logic [SIGLEN_W-1:0] len_clamped;
  logic [CNT_W-1:0]    consumed_eff, total_eff, consumed_inc;
  logic [LEN_W-1:0]    left_eff, length_eff;
  logic [BLOCK_W-1:0]  block_eff, hdr_block;
  logic                deliver_eff, active, hdr_ok;
  logic [LEN_W:0]      plen;

  always_comb begin
    len_clamped = (signal_length > CAP_LEN) ? CAP_LEN : signal_length;

    // A start word restarts framing before it is itself examined.
    if (start_of_signal) begin
      total_eff    = len_clamped[CNT_W-1:0];
      consumed_eff = '0;
      left_eff     = '0;
      block_eff    = '0;
      length_eff   = '0;
      deliver_eff  = 1'b0;
    end else begin
      total_eff    = total_r;
      consumed_eff = consumed_r;
      left_eff     = left_r;
      block_eff    = block_r;
      length_eff   = length_r;
      deliver_eff  = deliver_r;
    end

    active       = consumed_eff < total_eff;
    consumed_inc = consumed_eff + CNT_W'(1);
    plen         = {1'b0, data_word[LEN_W-1:0]} + LEN_BIAS;
    hdr_block    = data_word[BLOCK_SHIFT +: BLOCK_W];
    hdr_ok       = (plen <= LEN_LIMIT) &&
                   ((SUM_W'(plen) + SUM_W'(consumed_inc)) <= SUM_W'(total_eff));

    total_nxt    = total_eff;
    consumed_nxt = consumed_eff;
    left_nxt     = left_eff;
    block_nxt    = block_eff;
    length_nxt   = length_eff;
    deliver_nxt  = deliver_eff;
    res_valid    = 1'b0;

    res.dest_block     = block_eff;
    res.sub_length     = length_eff;
    res.payload_word   = data_word;
    res.word_index     = length_eff - left_eff;
    res.last_of_packet = (left_eff == LEN_W'(1));

    if (active) begin
      consumed_nxt = consumed_inc;
      if (left_eff == '0) begin
        if (hdr_ok) begin
          left_nxt    = plen[LEN_W-1:0];
          length_nxt  = plen[LEN_W-1:0];
          block_nxt   = hdr_block;
          deliver_nxt = hdr_block >= min_api_block;
        end
      end else begin
        left_nxt  = left_eff - LEN_W'(1);
        res_valid = accept && deliver_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      consumed_r <= '0;
      total_r    <= '0;
      left_r     <= '0;
      block_r    <= '0;
      length_r   <= '0;
      deliver_r  <= 1'b0;
    end else if (accept) begin
      consumed_r <= consumed_nxt;
      total_r    <= total_nxt;
      left_r     <= left_nxt;
      block_r    <= block_nxt;
      length_r   <= length_nxt;
      deliver_r  <= deliver_nxt;
    end
  end

endmodule

### sv/psd_out_reg.sv
// Result register between the framing logic and the result channel.
module psd_out_reg import psd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_valid,
  input  psd_result_t res,
  input  logic        out_ready,
  output logic        out_valid,
  output psd_result_t out_data,
  output logic        can_load
);

  logic        valid_r, valid_nxt;
  psd_result_t data_r;

  // The register may take a new result whenever it is empty or being drained.
  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = can_load ? res_valid : valid_r;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && res_valid) begin
      data_r <= res;
    end
  end

endmodule

### sv/psd_checker.sv
// Port-level checker of the packed signal deframer and its bind to the top level.
`include "packed_signal_deframer_core_macros.svh"

module psd_checker import psd_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [LEN_W-1:0]   out_sub_length,
  input logic [LEN_W-1:0]   out_word_index,
  input logic               out_last_of_packet,
  input logic [WORD_W-1:0]  out_payload_word,
  input logic [BLOCK_W-1:0] out_dest_block
);

  `PSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_payload_word) && $stable(out_dest_block) &&
                   $stable(out_word_index))
  `PSD_ASSERT_SAME(a_len_range, out_valid, out_sub_length >= 5'd3 && out_sub_length <= 5'd25)
  `PSD_ASSERT_SAME(a_index_range, out_valid, out_word_index < out_sub_length)
  `PSD_ASSERT_SAME(a_last_mark, out_valid,
                   out_last_of_packet == (out_word_index == out_sub_length - 5'd1))
  `PSD_ASSERT_SAME(a_ready_empty, !out_valid, in_ready)

endmodule

bind packed_signal_deframer_core psd_checker u_psd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_item.ready),
  .out_valid         (out_item.valid),
  .out_ready         (out_item.ready),
  .out_sub_length    (out_item.sub_length),
  .out_word_index    (out_item.word_index),
  .out_last_of_packet(out_item.last_of_packet),
  .out_payload_word  (out_item.payload_word),
  .out_dest_block    (out_item.dest_block)
);
